### hdl/hcbd_pkg.sv
// Shared types, constants and helpers for the chunked body decoder.
`default_nettype none

package hcbd_pkg;

    // Width of the chunk size counter
    localparam int SIZE_BITS = 32;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    typedef enum logic [2:0]
    {
        PH_LINE_START,
        PH_LINE_DIGITS,
        PH_LINE_OVER,
        PH_DATA,
        PH_TERM_A,
        PH_TERM_B,
        PH_FINAL_A,
        PH_FINAL_B
    } phase_t;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_DATA     = 2'd0;
    localparam kind_t KIND_END      = 2'd1;
    localparam kind_t KIND_SIZE_ERR = 2'd2;
    localparam kind_t KIND_TERM_ERR = 2'd3;

    typedef struct packed
    {
        phase_t                 phase;
        logic [SIZE_BITS-1:0]   remaining;
        logic                   digits_stopped;
        logic                   saw_cr;
    } dec_state_t;

    typedef struct packed
    {
        logic       valid;
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } result_t;

    typedef struct packed
    {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    localparam dec_state_t RESET_STATE = '{
        phase:          PH_LINE_START,
        remaining:      '0,
        digits_stopped: 1'b0,
        saw_cr:         1'b0
    };

    // Decode one ASCII hex digit; ok is low for any other character
    function automatic hex_t hex_digit(input logic [7:0] b);
        hex_t h;
        h.ok    = 1'b0;
        h.value = 4'd0;
        if (b inside {[8'h30:8'h39]})
        begin
            h.ok    = 1'b1;
            h.value = b[3:0];
        end
        else if (b inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            h.ok    = 1'b1;
            h.value = b[3:0] + 4'd9;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

### hdl/hcbd_step.sv
// Next-state and result logic for one received byte.
`default_nettype none

module hcbd_step
(
    input  wire hcbd_pkg::dec_state_t cur,
    input  wire logic [7:0]           in_byte,
    output hcbd_pkg::dec_state_t      nxt,
    output hcbd_pkg::result_t         res
);

    hcbd_pkg::hex_t                    hex;
    logic [hcbd_pkg::SIZE_BITS-1:0]    rem_dec;
    logic                              crlf;

    always_comb
    begin
        hex     = hcbd_pkg::hex_digit(in_byte);
        rem_dec = cur.remaining - {{(hcbd_pkg::SIZE_BITS-1){1'b0}}, 1'b1};
        crlf    = cur.saw_cr && (in_byte == hcbd_pkg::CHAR_LF);
        nxt     = cur;
        res     = '{valid: 1'b0, kind: hcbd_pkg::KIND_DATA, data: 8'd0, last: 1'b0};

        case (cur.phase)
            hcbd_pkg::PH_LINE_START, hcbd_pkg::PH_LINE_DIGITS, hcbd_pkg::PH_LINE_OVER:
            begin
                if (crlf)
                begin
                    // End of size line: start data, expect the final CRLF or flag a bad size
                    nxt = hcbd_pkg::RESET_STATE;
                    if (cur.phase != hcbd_pkg::PH_LINE_DIGITS)
                    begin
                        res = '{valid: 1'b1, kind: hcbd_pkg::KIND_SIZE_ERR,
                                data: 8'd0, last: 1'b1};
                    end
                    else if (cur.remaining == '0)
                    begin
                        nxt.phase = hcbd_pkg::PH_FINAL_A;
                    end
                    else
                    begin
                        nxt.phase     = hcbd_pkg::PH_DATA;
                        nxt.remaining = cur.remaining;
                    end
                end
                else
                begin
                    nxt.saw_cr = (in_byte == hcbd_pkg::CHAR_CR);
                    if (cur.phase == hcbd_pkg::PH_LINE_START)
                    begin
                        if (!cur.digits_stopped && hex.ok)
                        begin
                            nxt.phase     = hcbd_pkg::PH_LINE_DIGITS;
                            nxt.remaining = {{(hcbd_pkg::SIZE_BITS-4){1'b0}}, hex.value};
                        end
                        else
                        begin
                            nxt.digits_stopped = 1'b1;
                        end
                    end
                    else if (cur.phase == hcbd_pkg::PH_LINE_DIGITS)
                    begin
                        if (!cur.digits_stopped && hex.ok)
                        begin
                            // Top nibble busy: another digit would overflow
                            if (cur.remaining[hcbd_pkg::SIZE_BITS-1 -: 4] != 4'd0)
                            begin
                                nxt.phase = hcbd_pkg::PH_LINE_OVER;
                            end
                            else
                            begin
                                nxt.remaining = {cur.remaining[hcbd_pkg::SIZE_BITS-5:0],
                                                 hex.value};
                            end
                        end
                        else
                        begin
                            nxt.digits_stopped = 1'b1;
                        end
                    end
                end
            end

            hcbd_pkg::PH_DATA:
            begin
                nxt.remaining = rem_dec;
                if (rem_dec == '0)
                begin
                    nxt.phase  = hcbd_pkg::PH_TERM_A;
                    nxt.saw_cr = 1'b0;
                end
                res = '{valid: 1'b1, kind: hcbd_pkg::KIND_DATA, data: in_byte, last: 1'b0};
            end

            hcbd_pkg::PH_TERM_A:
            begin
                nxt.saw_cr = (in_byte == hcbd_pkg::CHAR_CR);
                nxt.phase  = hcbd_pkg::PH_TERM_B;
            end

            hcbd_pkg::PH_FINAL_A:
            begin
                nxt.saw_cr = (in_byte == hcbd_pkg::CHAR_CR);
                nxt.phase  = hcbd_pkg::PH_FINAL_B;
            end

            default:
            begin
                // Second terminator byte: close the chunk or the body, or flag a bad terminator
                nxt = hcbd_pkg::RESET_STATE;
                if (!crlf)
                begin
                    res = '{valid: 1'b1, kind: hcbd_pkg::KIND_TERM_ERR,
                            data: 8'd0, last: 1'b1};
                end
                else if (cur.phase == hcbd_pkg::PH_FINAL_B)
                begin
                    res = '{valid: 1'b1, kind: hcbd_pkg::KIND_END,
                            data: 8'd0, last: 1'b1};
                end
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/hcbd_out_reg.sv
// Result register driving the output channel.
`default_nettype none

module hcbd_out_reg
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire hcbd_pkg::result_t res,
    input  wire logic              out_stall,
    output logic                   free,
    output logic                   out_valid,
    output logic [1:0]             kind,
    output logic [7:0]             out_byte,
    output logic                   last
);

    logic       valid_reg;
    logic       valid_next;
    logic [1:0] kind_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= res.kind;
            byte_reg <= res.data;
            last_reg <= res.last;
        end
    end

    assign out_valid = valid_reg;
    assign kind      = kind_reg;
    assign out_byte  = byte_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

### hdl/http_chunked_body_decoder_top.sv
// Top level of the HTTP/1.1 chunked body decoder.
//
// Input channel: in_valid / in_stall / in_byte carries the body one byte per item.
// Output channel: out_valid / out_stall / kind, out_byte, last carries results:
// kind 0 is a payload byte in out_byte, kind 1 ends the body, kind 2 flags a bad
// chunk size line, kind 3 a bad chunk terminator. last marks kinds 1 to 3.
// Data bytes give one result each; size lines and terminators only on errors or end.
// A byte taken into the input register is decoded from there into the state and
// result registers, and its result shows on the output from the result register.
// Throughput: one byte per cycle unless a result is held by a receiver stall, set by
// the combinational decode between the input register and the state and result registers.
// When the receiver stalls with a result waiting, bytes that give no result still
// pass; a byte with a result holds in the input register and in_stall rises.
// Reset clears the decoder to the start of a size line and empties both registers.
// After a body end or an error the next byte starts a new body.
`default_nettype none

module http_chunked_body_decoder_top
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      kind,
    output logic [7:0]      out_byte,
    output logic            last
);

    logic                 item_valid_reg;
    logic                 item_valid_next;
    logic [7:0]           item_byte_reg;
    hcbd_pkg::dec_state_t state_reg;
    hcbd_pkg::dec_state_t state_next;
    hcbd_pkg::result_t    res;
    logic                 out_free;
    logic                 fire;
    logic                 accept;

    hcbd_step u_step
    (
        .cur     (state_reg),
        .in_byte (item_byte_reg),
        .nxt     (state_next),
        .res     (res)
    );

    hcbd_out_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire && res.valid),
        .res       (res),
        .out_stall (out_stall),
        .free      (out_free),
        .out_valid (out_valid),
        .kind      (kind),
        .out_byte  (out_byte),
        .last      (last)
    );

    // Advance the held byte unless its result has nowhere to go
    assign fire     = item_valid_reg && (out_free || !res.valid);
    assign in_stall = item_valid_reg && !fire;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (fire)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            state_reg      <= hcbd_pkg::RESET_STATE;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            if (fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_byte_reg <= in_byte;
        end
    end

endmodule

`default_nettype wire

### tb/tb_http_chunked_body_decoder_top.sv
// Testbench for the chunked body decoder: directed and random streams against a predictor.
`timescale 1ns / 1ps

module tb_http_chunked_body_decoder_top;

    typedef struct
    {
        hcbd_pkg::kind_t kind;
        logic [7:0]      data;
        logic            last;
    } body_ev_t;

    typedef struct
    {
        logic [7:0] b;
        bit         typed;
        body_ev_t   ev;
    } feed_t;

    localparam int DIRECTED_ITEMS = 27;
    localparam int RANDOM_ITEMS   = 1820;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;

    feed_t    feed_q[$];
    body_ev_t body_q[$];
    int       acc_cnt = 0;
    int       err_cnt = 0;

    // Predictor state
    hcbd_pkg::phase_t               pr_phase;
    logic [hcbd_pkg::SIZE_BITS-1:0] pr_left;
    bit                             pr_stopped;
    bit                             pr_cr;

    bit       mon_got;
    body_ev_t mon_ev;
    body_ev_t chk_ev;

    http_chunked_body_decoder_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .out_byte  (out_byte),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb_http_chunked_body_decoder_top: FAIL");
        $finish;
    end

    task automatic clear_decoder();
        pr_phase   = hcbd_pkg::PH_LINE_START;
        pr_left    = '0;
        pr_stopped = 1'b0;
        pr_cr      = 1'b0;
    endtask

    task automatic hex_of(input logic [7:0] c, output bit ok, output logic [3:0] v);
        ok = 1'b1;
        v  = 4'd0;
        if (c >= "0" && c <= "9")
            v = 4'(c - "0");
        else if (c >= "a" && c <= "f")
            v = 4'(c - "a" + 8'd10);
        else if (c >= "A" && c <= "F")
            v = 4'(c - "A" + 8'd10);
        else
            ok = 1'b0;
    endtask

    // Advance the predicted decoder by one byte; got is set when the byte yields a result
    task automatic decode_byte(input logic [7:0] b, output bit got, output body_ev_t ev);
        bit                             is_hex;
        logic [3:0]                     hv;
        hcbd_pkg::phase_t               ph;
        logic [hcbd_pkg::SIZE_BITS-1:0] sz;
        bit                             good;
        bit                             fin;
        got = 1'b0;
        ev  = '{hcbd_pkg::KIND_DATA, 8'h00, 1'b0};
        hex_of(b, is_hex, hv);
        case (pr_phase)
            hcbd_pkg::PH_LINE_START, hcbd_pkg::PH_LINE_DIGITS, hcbd_pkg::PH_LINE_OVER:
            begin
                if (pr_cr && b == hcbd_pkg::CHAR_LF)
                begin
                    ph = pr_phase;
                    sz = pr_left;
                    clear_decoder();
                    if (ph != hcbd_pkg::PH_LINE_DIGITS)
                    begin
                        got = 1'b1;
                        ev  = '{hcbd_pkg::KIND_SIZE_ERR, 8'h00, 1'b1};
                    end
                    else if (sz == '0)
                        pr_phase = hcbd_pkg::PH_FINAL_A;
                    else
                    begin
                        pr_phase = hcbd_pkg::PH_DATA;
                        pr_left  = sz;
                    end
                end
                else
                begin
                    pr_cr = (b == hcbd_pkg::CHAR_CR);
                    if (pr_phase == hcbd_pkg::PH_LINE_START)
                    begin
                        if (!pr_stopped && is_hex)
                        begin
                            pr_phase = hcbd_pkg::PH_LINE_DIGITS;
                            pr_left  = hcbd_pkg::SIZE_BITS'(hv);
                        end
                        else
                            pr_stopped = 1'b1;
                    end
                    else if (pr_phase == hcbd_pkg::PH_LINE_DIGITS)
                    begin
                        if (!pr_stopped && is_hex)
                        begin
                            // a further digit would shift bits out of the counter
                            if (pr_left[hcbd_pkg::SIZE_BITS-1 -: 4] != 4'd0)
                                pr_phase = hcbd_pkg::PH_LINE_OVER;
                            else
                                pr_left = {pr_left[hcbd_pkg::SIZE_BITS-5:0], hv};
                        end
                        else
                            pr_stopped = 1'b1;
                    end
                end
            end
            hcbd_pkg::PH_DATA:
            begin
                pr_left = pr_left - 1'b1;
                if (pr_left == '0)
                begin
                    pr_phase = hcbd_pkg::PH_TERM_A;
                    pr_cr    = 1'b0;
                end
                got = 1'b1;
                ev  = '{hcbd_pkg::KIND_DATA, b, 1'b0};
            end
            hcbd_pkg::PH_TERM_A, hcbd_pkg::PH_FINAL_A:
            begin
                pr_cr    = (b == hcbd_pkg::CHAR_CR);
                pr_phase = (pr_phase == hcbd_pkg::PH_TERM_A) ? hcbd_pkg::PH_TERM_B
                                                             : hcbd_pkg::PH_FINAL_B;
            end
            default:
            begin
                good = pr_cr && b == hcbd_pkg::CHAR_LF;
                fin  = (pr_phase == hcbd_pkg::PH_FINAL_B);
                clear_decoder();
                if (!good)
                begin
                    got = 1'b1;
                    ev  = '{hcbd_pkg::KIND_TERM_ERR, 8'h00, 1'b1};
                end
                else if (fin)
                begin
                    got = 1'b1;
                    ev  = '{hcbd_pkg::KIND_END, 8'h00, 1'b1};
                end
            end
        endcase
    endtask

    task automatic put(input logic [7:0] b, input bit typed = 1'b0,
                       input hcbd_pkg::kind_t k = hcbd_pkg::KIND_DATA,
                       input logic [7:0] d = 8'h00, input logic l = 1'b0);
        feed_t f;
        f.b     = b;
        f.typed = typed;
        f.ev    = '{k, d, l};
        feed_q.push_back(f);
    endtask

    function automatic logic [7:0] hex_char(input int v);
        if (v < 10)
            return 8'("0" + v);
        if ($urandom_range(0, 1) == 0)
            return 8'("a" + v - 10);
        return 8'("A" + v - 10);
    endfunction

    // Byte biased towards the characters the decoder cares about
    function automatic logic [7:0] odd_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return hcbd_pkg::CHAR_CR;
        if (r < 50)
            return hcbd_pkg::CHAR_LF;
        if (r < 75)
            return hex_char($urandom_range(0, 15));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic size_line_tail();
        if ($urandom_range(0, 9) < 3)
        begin
            put(";");
            repeat ($urandom_range(0, 6))
                put(8'($urandom_range(32, 126)));
        end
        if ($urandom_range(0, 9) == 0)
        begin
            put(hcbd_pkg::CHAR_CR);
            put(8'($urandom_range(32, 126)));
        end
        put(hcbd_pkg::CHAR_CR);
        put(hcbd_pkg::CHAR_LF);
    endtask

    task automatic put_terminator();
        if ($urandom_range(0, 99) < 94)
        begin
            put(hcbd_pkg::CHAR_CR);
            put(hcbd_pkg::CHAR_LF);
        end
        else
        begin
            put(odd_byte());
            put(odd_byte());
        end
    endtask

    task automatic build_random_stream();
        int pick;
        int n;
        int sz;
        int nd;
        int k;
        int j;
        while (feed_q.size() < DIRECTED_ITEMS + RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                // body with random content, well-formed but for an occasional broken terminator
                n = $urandom_range(0, 4);
                for (j = 0; j < n; j++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        sz = $urandom_range(13, 300);
                    else
                        sz = $urandom_range(1, 12);
                    if ($urandom_range(0, 9) == 0)
                        repeat ($urandom_range(1, 2))
                            put("0");
                    nd = 1;
                    while ((sz >> (4 * nd)) != 0)
                        nd++;
                    for (k = nd - 1; k >= 0; k--)
                        put(hex_char((sz >> (4 * k)) & 15));
                    size_line_tail();
                    repeat (sz)
                        put(8'($urandom_range(0, 255)));
                    put_terminator();
                end
                repeat ($urandom_range(1, 3))
                    put("0");
                size_line_tail();
                put_terminator();
            end
            else if (pick < 87)
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        put(hcbd_pkg::CHAR_CR);
                        put(hcbd_pkg::CHAR_LF);
                    end
                    1:
                    begin
                        put(8'("g" + $urandom_range(0, 19)));
                        repeat ($urandom_range(0, 3))
                            put(hex_char($urandom_range(0, 15)));
                        size_line_tail();
                    end
                    default:
                    begin
                        put(hex_char($urandom_range(1, 15)));
                        repeat ($urandom_range(8, 11))
                            put(hex_char($urandom_range(0, 15)));
                        size_line_tail();
                    end
                endcase
            end
            else
            begin
                repeat ($urandom_range(1, 16))
                    put(odd_byte());
            end
        end
    endtask

    function automatic int pause_len(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Predict on every accepted item
    always @(posedge clk)
    begin
        if (rst_n && in_valid === 1'b1 && in_stall === 1'b0)
        begin
            decode_byte(in_byte, mon_got, mon_ev);
            if (feed_q[acc_cnt].typed)
            begin
                mon_got = 1'b1;
                mon_ev  = feed_q[acc_cnt].ev;
            end
            if (mon_got)
                body_q.push_back(mon_ev);
            acc_cnt++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (body_q.size() == 0)
            begin
                $error("result with none expected: kind %0d out_byte %02h last %0d",
                       kind, out_byte, last);
                err_cnt++;
            end
            else
            begin
                chk_ev = body_q.pop_front();
                if (kind !== chk_ev.kind)
                begin
                    $error("kind: expected %0d, got %0d", chk_ev.kind, kind);
                    err_cnt++;
                end
                if (out_byte !== chk_ev.data)
                begin
                    $error("out_byte: expected %02h, got %02h", chk_ev.data, out_byte);
                    err_cnt++;
                end
                if (last !== chk_ev.last)
                begin
                    $error("last: expected %0d, got %0d", chk_ev.last, last);
                    err_cnt++;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off to back the block up
    initial
    begin : rx_side
        int s;
        bit held;
        bit rx_calm;
        held    = 1'b0;
        rx_calm = 1'b0;
        out_stall <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!held && acc_cnt >= 700)
            begin
                s    = 400;
                held = 1'b1;
            end
            else
            begin
                if ($urandom_range(0, 199) == 0)
                    rx_calm = !rx_calm;
                s = pause_len(rx_calm);
            end
            if (s > 0)
            begin
                out_stall <= 1'b1;
                repeat (s) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
        end
    end

    initial
    begin : tx_side
        int  i;
        int  gap;
        bit  tx_calm;
        tx_calm = 1'b0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_byte  <= 8'h00;
        clear_decoder();

        // empty size line with a lone CR in it
        put(hcbd_pkg::CHAR_CR);
        put(hcbd_pkg::CHAR_CR);
        put(hcbd_pkg::CHAR_LF, 1'b1, hcbd_pkg::KIND_SIZE_ERR, 8'h00, 1'b1);
        // two data bytes at the extremes, then a broken terminator
        put("2");
        put(hcbd_pkg::CHAR_CR);
        put(hcbd_pkg::CHAR_LF);
        put(8'h00, 1'b1, hcbd_pkg::KIND_DATA, 8'h00, 1'b0);
        put(8'hFF, 1'b1, hcbd_pkg::KIND_DATA, 8'hFF, 1'b0);
        put("X");
        put(hcbd_pkg::CHAR_LF, 1'b1, hcbd_pkg::KIND_TERM_ERR, 8'h00, 1'b1);
        // zero size written with two digits ends the body
        put("0");
        put("0");
        put(hcbd_pkg::CHAR_CR);
        put(hcbd_pkg::CHAR_LF);
        put(hcbd_pkg::CHAR_CR);
        put(hcbd_pkg::CHAR_LF, 1'b1, hcbd_pkg::KIND_END, 8'h00, 1'b1);
        // nine digits overflow the counter
        put("F");
        repeat (8)
            put("f");
        put(hcbd_pkg::CHAR_CR);
        put(hcbd_pkg::CHAR_LF, 1'b1, hcbd_pkg::KIND_SIZE_ERR, 8'h00, 1'b1);

        build_random_stream();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < feed_q.size(); i++)
        begin
            if ($urandom_range(0, 199) == 0)
                tx_calm = !tx_calm;
            gap = pause_len(tx_calm);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_byte  <= feed_q[i].b;
            do
                @(posedge clk);
            while (in_stall !== 1'b0);
        end
        in_valid <= 1'b0;

        while (body_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (body_q.size() != 0)
        begin
            $error("%0d results never arrived", body_q.size());
            err_cnt++;
        end

        if (err_cnt == 0)
            $display("tb_http_chunked_body_decoder_top: PASS");
        else
            $display("tb_http_chunked_body_decoder_top: FAIL");
        $finish;
    end

endmodule
